>>> rtl/u256div_pkg.sv
// ----------------------------------------------------------------------------
// u256div_pkg
// Shared types and constants for the 256-bit unsigned restoring divider.
// ----------------------------------------------------------------------------
package u256div_pkg;

  localparam int unsigned LIMB_W  = 64;
  localparam int unsigned LIMBS   = 4;
  localparam int unsigned WORD_W  = LIMB_W * LIMBS;
  localparam int unsigned COUNT_W = $clog2(WORD_W);
  localparam logic [COUNT_W-1:0] LAST_BIT = COUNT_W'(WORD_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

>>> rtl/u256div_dp.sv
// ----------------------------------------------------------------------------
// u256div_dp
// Datapath: partial remainder, dividend/quotient shift register, bit counter
// and the result register.
// ----------------------------------------------------------------------------
module u256div_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  u256div_pkg::dp_cmd_t             cmd,
  output u256div_pkg::dp_sts_t             sts,
  input  logic [u256div_pkg::WORD_W-1:0]   dividend,
  input  logic [u256div_pkg::WORD_W-1:0]   divisor,
  output logic [u256div_pkg::WORD_W-1:0]   quotient,
  output logic                             divide_by_zero
);

  logic [u256div_pkg::WORD_W-1:0]  rem;
  logic [u256div_pkg::WORD_W-1:0]  num;
  logic [u256div_pkg::WORD_W-1:0]  den;
  logic                            den_zero;
  logic [u256div_pkg::COUNT_W-1:0] count;
  logic [u256div_pkg::WORD_W:0]    shifted;
  logic [u256div_pkg::WORD_W+1:0]  diff;
  logic                            qbit;

  assign shifted = {rem, num[u256div_pkg::WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign qbit    = ~diff[u256div_pkg::WORD_W+1];
  assign sts.last = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= u256div_pkg::LAST_BIT;
    end else if (cmd.step) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem      <= '0;
      num      <= dividend;
      den      <= divisor;
      den_zero <= (divisor == '0);
    end else if (cmd.step) begin
      if (qbit) begin
        rem <= diff[u256div_pkg::WORD_W-1:0];
      end else begin
        rem <= shifted[u256div_pkg::WORD_W-1:0];
      end
      num <= {num[u256div_pkg::WORD_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      quotient       <= den_zero ? '0 : num;
      divide_by_zero <= den_zero;
    end
  end

endmodule

>>> rtl/u256div_ctrl.sv
// ----------------------------------------------------------------------------
// u256div_ctrl
// Controller: sequences load, 256 division steps and result capture, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module u256div_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u256div_pkg::dp_cmd_t cmd,
  input  u256div_pkg::dp_sts_t sts
);

  u256div_pkg::state_t state;
  u256div_pkg::state_t state_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= u256div_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    unique case (state)
      u256div_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = u256div_pkg::ST_RUN;
        end
      end
      u256div_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = u256div_pkg::ST_DRAIN;
        end
      end
      u256div_pkg::ST_DRAIN: begin
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = u256div_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = u256div_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_load_runs: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == u256div_pkg::ST_RUN))
    else $error("accepted transaction did not start the division");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (state == u256div_pkg::ST_RUN && sts.last) |=> (state == u256div_pkg::ST_DRAIN))
    else $error("final step did not move to drain");

  a_capture_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> out_valid)
    else $error("captured result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

endmodule

>>> rtl/u256_restoring_divider.sv
// ----------------------------------------------------------------------------
// u256_restoring_divider
// Unsigned 256-bit by 256-bit restoring divider, stream interface.
// ----------------------------------------------------------------------------
// A result is valid after its transaction is accepted, runs through 256
// shift-and-subtract steps (one quotient bit per cycle, set by the single
// 258-bit subtractor) and passes the drain state, which moves the quotient
// into the output register. The next transaction is accepted the cycle after
// capture, so a new transaction is never taken while one is in progress;
// capture waits while the previous result still sits unaccepted in the output
// register. A zero divisor yields an all-zero quotient with m_tuser set.
// ----------------------------------------------------------------------------
module u256_restoring_divider (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dividend_limb0..3, divisor_limb0..3, 64 bits each
  input  logic [511:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // quotient_limb0..3, 64 bits each
  output logic [255:0] m_tdata,
  // divide_by_zero
  output logic         m_tuser
);

  u256div_pkg::dp_cmd_t cmd;
  u256div_pkg::dp_sts_t sts;

  u256div_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  u256div_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .dividend       (s_tdata[255:0]),
    .divisor        (s_tdata[511:256]),
    .quotient       (m_tdata),
    .divide_by_zero (m_tuser)
  );

endmodule
